// ===== hw/rtl/csort_pkg.sv =====
// Shared constants, state type and compare function of the shaker sorter.
`timescale 1ns / 1ps
package csort_pkg;

	localparam int DEPTH  = 64;
	localparam int KEY_W  = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PREP,
		ST_FWD_START,
		ST_FWD_FIRST,
		ST_FWD_RUN,
		ST_FWD_PUT,
		ST_BWD_START,
		ST_BWD_FIRST,
		ST_BWD_RUN,
		ST_BWD_PUT,
		ST_EMIT_RD,
		ST_EMIT_DATA
	} state_t;

	// True when key a must come after key b in the selected order.
	function automatic logic after(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
			input logic desc);
		after = desc ? (a < b) : (a > b);
	endfunction

endpackage

// ===== hw/rtl/csort_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module csort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/cocktail_shift_sorter_unit.sv =====
// Top level of the shaker sorter: key memory, sort sequencer and output register.
`timescale 1ns / 1ps
// Keys are loaded one per cycle into a 64-entry key memory; the transaction with is_last
// starts the sort and no further keys are taken until the last sorted key has been moved
// into the output register. The sort alternates forward and backward passes over the
// shrinking unsorted window; each pass reads one entry and writes one entry per cycle
// through the memory's single read and single write port, so the sort time is set by the
// number of passes the order needs. Each key is then emitted in two steps: a memory read,
// then a load of the output register, which waits until that register is free.
// Keys beyond 64 are dropped and every result of that set carries overflow.
module cocktail_shift_sorter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] element_key,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sorted_key,
	output logic        end_of_run,
	output logic        overflow,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	localparam int AW = csort_pkg::ADDR_W;
	localparam int CW = csort_pkg::CNT_W;
	localparam int KW = csort_pkg::KEY_W;

	csort_pkg::state_t state_q, state_d;

	logic          descending_q;
	logic [CW-1:0] count_q;
	logic          dropped_q;
	logic [AW-1:0] first_q, last_q, idx_q, swap_pos_q;
	logic          swap_q;
	logic [KW-1:0] carry_q;
	logic [CW-1:0] emit_q;

	logic          out_valid_q;
	logic [31:0]   sorted_key_q;
	logic          end_of_run_q, overflow_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [KW-1:0] ram_wdata, ram_rdata;

	logic in_fire, out_free, emit_last, fwd_move, bwd_move, store_full;

	csort_ram #(
		.WIDTH(KW),
		.DEPTH(csort_pkg::DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign emit_last  = (emit_q == CW'(count_q - CW'(1)));
	assign store_full = (count_q == CW'(csort_pkg::DEPTH));
	// The carried key moves on when it belongs after the key just read.
	assign fwd_move   = csort_pkg::after(carry_q, ram_rdata, descending_q);
	assign bwd_move   = csort_pkg::after(ram_rdata, carry_q, descending_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			csort_pkg::ST_LOAD: begin
				if (in_fire && is_last) state_d = csort_pkg::ST_PREP;
			end
			csort_pkg::ST_PREP: begin
				state_d = (count_q <= CW'(1)) ? csort_pkg::ST_EMIT_RD : csort_pkg::ST_FWD_START;
			end
			csort_pkg::ST_FWD_START: state_d = csort_pkg::ST_FWD_FIRST;
			csort_pkg::ST_FWD_FIRST: state_d = csort_pkg::ST_FWD_RUN;
			csort_pkg::ST_FWD_RUN: begin
				if (idx_q == last_q) state_d = csort_pkg::ST_FWD_PUT;
			end
			csort_pkg::ST_FWD_PUT: begin
				state_d = (!swap_q || first_q >= swap_pos_q) ? csort_pkg::ST_EMIT_RD
					: csort_pkg::ST_BWD_START;
			end
			csort_pkg::ST_BWD_START: state_d = csort_pkg::ST_BWD_FIRST;
			csort_pkg::ST_BWD_FIRST: state_d = csort_pkg::ST_BWD_RUN;
			csort_pkg::ST_BWD_RUN: begin
				if (idx_q == first_q) state_d = csort_pkg::ST_BWD_PUT;
			end
			csort_pkg::ST_BWD_PUT: begin
				state_d = (!swap_q || swap_pos_q >= last_q) ? csort_pkg::ST_EMIT_RD
					: csort_pkg::ST_FWD_START;
			end
			csort_pkg::ST_EMIT_RD: state_d = csort_pkg::ST_EMIT_DATA;
			csort_pkg::ST_EMIT_DATA: begin
				if (out_free) state_d = emit_last ? csort_pkg::ST_LOAD : csort_pkg::ST_EMIT_RD;
			end
			default: state_d = csort_pkg::ST_LOAD;
		endcase
	end

	// Memory port and handshake outputs.
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = carry_q;
		ram_raddr = idx_q;
		case (state_q)
			csort_pkg::ST_LOAD: begin
				in_ready  = 1'b1;
				ram_we    = in_fire && !store_full;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = element_key[KW-1:0];
			end
			csort_pkg::ST_FWD_START: ram_raddr = first_q;
			csort_pkg::ST_FWD_FIRST: ram_raddr = first_q + AW'(1);
			csort_pkg::ST_FWD_RUN: begin
				ram_raddr = idx_q + AW'(1);
				ram_we    = 1'b1;
				ram_waddr = idx_q - AW'(1);
				ram_wdata = fwd_move ? ram_rdata : carry_q;
			end
			csort_pkg::ST_FWD_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = last_q;
			end
			csort_pkg::ST_BWD_START: ram_raddr = last_q;
			csort_pkg::ST_BWD_FIRST: ram_raddr = last_q - AW'(1);
			csort_pkg::ST_BWD_RUN: begin
				ram_raddr = idx_q - AW'(1);
				ram_we    = 1'b1;
				ram_waddr = idx_q + AW'(1);
				ram_wdata = bwd_move ? ram_rdata : carry_q;
			end
			csort_pkg::ST_BWD_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = first_q;
			end
			csort_pkg::ST_EMIT_RD: ram_raddr = emit_q[AW-1:0];
			csort_pkg::ST_EMIT_DATA: ram_raddr = emit_q[AW-1:0];
			default: ram_we = 1'b0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= csort_pkg::ST_LOAD;
			descending_q <= 1'b0;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) descending_q <= cfg_wdata;
			if (in_fire) begin
				if (store_full) dropped_q <= 1'b1;
				else count_q <= count_q + CW'(1);
			end
			if (state_q == csort_pkg::ST_EMIT_DATA && out_free) begin
				out_valid_q <= 1'b1;
				if (emit_last) begin
					count_q   <= '0;
					dropped_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sort datapath and output payload.
	always_ff @(posedge clk) begin
		case (state_q)
			csort_pkg::ST_PREP: begin
				first_q <= '0;
				last_q  <= AW'(count_q - CW'(1));
				emit_q  <= '0;
			end
			csort_pkg::ST_FWD_START: swap_q <= 1'b0;
			csort_pkg::ST_FWD_FIRST: begin
				carry_q <= ram_rdata;
				idx_q   <= first_q + AW'(1);
			end
			csort_pkg::ST_FWD_RUN: begin
				if (fwd_move) begin
					swap_q     <= 1'b1;
					swap_pos_q <= idx_q - AW'(1);
				end else begin
					carry_q <= ram_rdata;
				end
				idx_q <= idx_q + AW'(1);
			end
			csort_pkg::ST_FWD_PUT: begin
				// Everything past the last exchange is in its final place.
				if (swap_q) last_q <= swap_pos_q;
			end
			csort_pkg::ST_BWD_START: swap_q <= 1'b0;
			csort_pkg::ST_BWD_FIRST: begin
				carry_q <= ram_rdata;
				idx_q   <= last_q - AW'(1);
			end
			csort_pkg::ST_BWD_RUN: begin
				if (bwd_move) begin
					swap_q     <= 1'b1;
					swap_pos_q <= idx_q + AW'(1);
				end else begin
					carry_q <= ram_rdata;
				end
				idx_q <= idx_q - AW'(1);
			end
			csort_pkg::ST_BWD_PUT: begin
				if (swap_q) first_q <= swap_pos_q;
			end
			csort_pkg::ST_EMIT_DATA: begin
				if (out_free) begin
					sorted_key_q <= 32'(ram_rdata);
					end_of_run_q <= emit_last;
					overflow_q   <= dropped_q;
					emit_q       <= emit_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign sorted_key = sorted_key_q;
	assign end_of_run = end_of_run_q;
	assign overflow   = overflow_q;

endmodule
